@@ hdl/ilir_pkg.sv @@
// Shared types and constants for the indexed list insert/remove unit.
`timescale 1ns / 1ps
package ilir_pkg;

  localparam int ILIR_CAPACITY = 32;
  localparam int ILIR_POS_W    = 6;
  localparam int ILIR_VALUE_W  = 32;
  localparam int ILIR_COUNT_W  = 7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    DP_NONE   = 3'd0,
    DP_APPEND = 3'd1,
    DP_INSERT = 3'd2,
    DP_REMOVE = 3'd3,
    DP_ROTATE = 3'd4
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    load_out;
    status_t out_status;
    logic    out_last;
    logic    out_dump;
    logic    clr_idx;
    logic    inc_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic ins_range_err;
    logic rem_range_err;
    logic idx_at_end;
  } dp_stat_t;

endpackage

@@ hdl/ilir_ctrl.sv @@
// Controller state machine of the indexed list insert/remove unit.
`timescale 1ns / 1ps
module ilir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  input  ilir_pkg::dp_stat_t stat_i,
  output ilir_pkg::dp_cmd_t  cmd_o
);
  import ilir_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    slot_free;
  dp_cmd_t cmd;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign out_valid = out_valid_r;
  assign cmd_o     = cmd;

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = DP_NONE;
    cmd.load_out   = 1'b0;
    cmd.out_status = ST_OK;
    cmd.out_last   = 1'b1;
    cmd.out_dump   = 1'b0;
    cmd.clr_idx    = 1'b0;
    cmd.inc_idx    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_out = 1'b1;
          case (op_t'(in_operation))
            OP_APPEND: begin
              if (stat_i.full) cmd.out_status = ST_FULL;
              else cmd.op = DP_APPEND;
            end
            OP_INSERT: begin
              if (stat_i.ins_range_err) cmd.out_status = ST_RANGE;
              else if (stat_i.full) cmd.out_status = ST_FULL;
              else cmd.op = DP_INSERT;
            end
            OP_REMOVE: begin
              if (stat_i.rem_range_err) cmd.out_status = ST_RANGE;
              else cmd.op = DP_REMOVE;
            end
            default: begin
              if (stat_i.count_zero) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.load_out = 1'b0;
                cmd.clr_idx  = 1'b1;
                state_nxt    = S_DUMP;
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_dump = 1'b1;
          cmd.out_last = stat_i.idx_at_end;
          cmd.op       = DP_ROTATE;
          cmd.inc_idx  = 1'b1;
          if (stat_i.idx_at_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/ilir_dp.sv @@
// Datapath of the indexed list insert/remove unit: shifting cells, count and result register.
`timescale 1ns / 1ps
module ilir_dp #(
  parameter int CAPACITY = ilir_pkg::ILIR_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ilir_pkg::ILIR_POS_W-1:0]   in_position,
  input  logic signed [ilir_pkg::ILIR_VALUE_W-1:0] in_value,
  input  ilir_pkg::dp_cmd_t                 cmd_i,
  output ilir_pkg::dp_stat_t                stat_o,
  output logic [1:0]                        out_status,
  output logic signed [ilir_pkg::ILIR_VALUE_W-1:0] out_entry_value,
  output logic [ilir_pkg::ILIR_POS_W-1:0]   out_entry_position,
  output logic [ilir_pkg::ILIR_COUNT_W-1:0] out_entry_count,
  output logic                              out_last
);
  import ilir_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic signed [ILIR_VALUE_W-1:0] cells_r   [CAPACITY];
  logic signed [ILIR_VALUE_W-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [ILIR_COUNT_W-1:0] count_x, pos_x;

  logic [1:0]                     status_r;
  logic signed [ILIR_VALUE_W-1:0] value_r;
  logic [ILIR_POS_W-1:0]          position_r;
  logic [ILIR_COUNT_W-1:0]        ecount_r;
  logic                           last_r;

  assign count_x = ILIR_COUNT_W'(count_r);
  assign pos_x   = ILIR_COUNT_W'(in_position);

  assign stat_o.count_zero    = (count_r == '0);
  assign stat_o.full          = (count_x == ILIR_COUNT_W'(CAPACITY));
  assign stat_o.ins_range_err = (pos_x > count_x);
  assign stat_o.rem_range_err = (pos_x >= count_x);
  assign stat_o.idx_at_end    = (ILIR_COUNT_W'(idx_r) + 1'b1 == count_x);

  always_comb begin
    case (cmd_i.op)
      DP_APPEND, DP_INSERT: count_nxt = count_r + 1'b1;
      DP_REMOVE:            count_nxt = count_r - 1'b1;
      default:              count_nxt = count_r;
    endcase
  end

  // Every cell picks its own next word from its neighbours, from the input word or, on a rotate, from cell 0.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [ILIR_COUNT_W-1:0] GI = ILIR_COUNT_W'(g);
    logic signed [ILIR_VALUE_W-1:0] below, above;
    if (g > 0) begin : g_below
      assign below = cells_r[g-1];
    end else begin : g_nobelow
      assign below = cells_r[0];
    end
    if (g < CAPACITY - 1) begin : g_above
      assign above = cells_r[g+1];
    end else begin : g_noabove
      assign above = cells_r[g];
    end
    always_comb begin
      cells_nxt[g] = cells_r[g];
      case (cmd_i.op)
        DP_APPEND: begin
          if (GI == count_x) cells_nxt[g] = in_value;
        end
        DP_INSERT: begin
          if (GI == pos_x) cells_nxt[g] = in_value;
          else if (GI > pos_x && GI <= count_x) cells_nxt[g] = below;
        end
        DP_REMOVE: begin
          if (GI >= pos_x && GI + 1'b1 < count_x) cells_nxt[g] = above;
        end
        DP_ROTATE: begin
          if (GI + 1'b1 < count_x) cells_nxt[g] = above;
          else if (GI + 1'b1 == count_x) cells_nxt[g] = cells_r[0];
        end
        default: cells_nxt[g] = cells_r[g];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) cells_r[i] <= cells_nxt[i];
    if (cmd_i.clr_idx) idx_r <= '0;
    else if (cmd_i.inc_idx) idx_r <= idx_r + 1'b1;
    if (cmd_i.load_out) begin
      status_r   <= cmd_i.out_status;
      value_r    <= cmd_i.out_dump ? cells_r[0] : '0;
      position_r <= cmd_i.out_dump ? ILIR_POS_W'(idx_r) : '0;
      ecount_r   <= ILIR_COUNT_W'(count_nxt);
      last_r     <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_status         = status_r;
  assign out_entry_value    = value_r;
  assign out_entry_position = position_r;
  assign out_entry_count    = ecount_r;
  assign out_last           = last_r;

endmodule

@@ hdl/indexed_list_insert_remove_unit.sv @@
// Top level of the indexed list insert/remove unit.
`timescale 1ns / 1ps
// An ordered list of up to CAPACITY signed 32-bit words, kept in a row of
// registers that all shift together. Each input item carries one operation:
// append, insert at a position, remove at a position, or dump. An append,
// insert or remove yields exactly one result item with last set; bad
// positions report status 1 and a full list status 2, leaving the list
// unchanged. A dump yields one result item per used entry, in order, with
// last on the final one, or a single status 3 item for an empty list. After
// a dump of a non-empty list is accepted, the input is held off until its
// final entry has been loaded into the result register; the list rotates
// one place per cycle while the result register is free, past cell 0, which
// feeds the result register, so it ends in its original order. While a dump
// runs no new input item is taken.
// Edits may follow one another in consecutive cycles while out_ready stays
// high. The result register holds a single item: a new input item is taken
// only when that register is empty or its item leaves in the same cycle, so
// a stalled result also stalls the input.
module indexed_list_insert_remove_unit #(
  parameter int CAPACITY = ilir_pkg::ILIR_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic [ilir_pkg::ILIR_POS_W-1:0]   in_position,
  input  logic signed [ilir_pkg::ILIR_VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [ilir_pkg::ILIR_VALUE_W-1:0] out_entry_value,
  output logic [ilir_pkg::ILIR_POS_W-1:0]   out_entry_position,
  output logic [ilir_pkg::ILIR_COUNT_W-1:0] out_entry_count,
  output logic                              out_last
);
  import ilir_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller decides what happens to each item; the datapath holds
  // the list, its count and the result register.
  ilir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ilir_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_position       (in_position),
    .in_value          (in_value),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_status        (out_status),
    .out_entry_value   (out_entry_value),
    .out_entry_position(out_entry_position),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

`ifndef SYNTH
  // An accepted edit produces its single result item in the next cycle.
  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation != OP_DUMP) |=> (out_valid && out_last))
    else $error("edit item did not yield a final result item");

  // An empty dump reports a zero count and closes the item at once.
  a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_last && out_entry_count == '0))
    else $error("empty-list result item malformed");

  // Only dump results can be non-final, and they are always good.
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("non-final result item carries an error status");

  // A new item is never taken while a dump is still part way through.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid && !out_last))
    else $error("input taken in the middle of a dump");

  // The count never goes beyond the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= ILIR_COUNT_W'(CAPACITY)))
    else $error("entry count above capacity");
`endif

endmodule

@@ verif/ilir_list_checker.sv @@
// Checker for the indexed list unit: predicts every result item and compares it.
`timescale 1ns / 1ps
module ilir_list_checker #(
  parameter int CAPACITY = ilir_pkg::ILIR_CAPACITY
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic [1:0]                               in_operation,
  input  logic [ilir_pkg::ILIR_POS_W-1:0]          in_position,
  input  logic signed [ilir_pkg::ILIR_VALUE_W-1:0] in_value,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic [1:0]                               out_status,
  input  logic signed [ilir_pkg::ILIR_VALUE_W-1:0] out_entry_value,
  input  logic [ilir_pkg::ILIR_POS_W-1:0]          out_entry_position,
  input  logic [ilir_pkg::ILIR_COUNT_W-1:0]        out_entry_count,
  input  logic                                     out_last,
  output int                                       fail_count,
  output int                                       pending_count
);
  import ilir_pkg::*;

  typedef struct {
    status_t                  status;
    logic signed [ILIR_VALUE_W-1:0] value;
    logic [ILIR_POS_W-1:0]    position;
    logic [ILIR_COUNT_W-1:0]  count;
    logic                     last;
  } list_result_t;

  // Our own copy of the list and the results still owed by the block.
  logic signed [ILIR_VALUE_W-1:0] list_words [CAPACITY];
  int                             list_len = 0;
  list_result_t                   expected_items [$];
  list_result_t                   oldest_item;
  int                             mismatches = 0;
  int                             owed = 0;

  assign fail_count    = mismatches;
  assign pending_count = owed;

  function automatic list_result_t result_of(status_t st, logic signed [31:0] val,
                                             int pos, int len, logic is_last);
    list_result_t r;
    r.status   = st;
    r.value    = val;
    r.position = pos[ILIR_POS_W-1:0];
    r.count    = len[ILIR_COUNT_W-1:0];
    r.last     = is_last;
    return r;
  endfunction

  // Applies one operation to the list copy and queues the result items it causes.
  task automatic predict_list_op(op_t op, int pos, logic signed [31:0] val);
    status_t st;
    int      i;
    st = ST_OK;
    if (op == OP_DUMP) begin
      if (list_len == 0) begin
        expected_items.push_back(result_of(ST_EMPTY, 0, 0, 0, 1'b1));
      end else begin
        for (i = 0; i < list_len; i++)
          expected_items.push_back(result_of(ST_OK, list_words[i], i, list_len,
                                             i == list_len - 1));
      end
    end else begin
      case (op)
        OP_APPEND: begin
          if (list_len >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            list_words[list_len] = val;
            list_len++;
          end
        end
        OP_INSERT: begin
          // The range check takes priority over the full check.
          if (pos > list_len) begin
            st = ST_RANGE;
          end else if (list_len >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            for (i = list_len; i > pos; i--)
              list_words[i] = list_words[i-1];
            list_words[pos] = val;
            list_len++;
          end
        end
        default: begin
          if (pos >= list_len) begin
            st = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < list_len; i++)
              list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      endcase
      expected_items.push_back(result_of(st, 0, 0, list_len, 1'b1));
    end
  endtask

  // Results are compared before new expectations are queued: a result can
  // never belong to an item accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      expected_items.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          $error("result item with no expectation pending");
          mismatches++;
        end else begin
          oldest_item = expected_items.pop_front();
          if (out_status !== oldest_item.status) begin
            $error("status: expected %0d, actual %0d", oldest_item.status, out_status);
            mismatches++;
          end
          if (out_entry_value !== oldest_item.value) begin
            $error("entry_value: expected %0d, actual %0d", oldest_item.value,
                   out_entry_value);
            mismatches++;
          end
          if (out_entry_position !== oldest_item.position) begin
            $error("entry_position: expected %0d, actual %0d", oldest_item.position,
                   out_entry_position);
            mismatches++;
          end
          if (out_entry_count !== oldest_item.count) begin
            $error("entry_count: expected %0d, actual %0d", oldest_item.count,
                   out_entry_count);
            mismatches++;
          end
          if (out_last !== oldest_item.last) begin
            $error("last: expected %0d, actual %0d", oldest_item.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_list_op(op_t'(in_operation), int'(in_position), in_value);
    end
    owed = expected_items.size();
  end

endmodule

@@ verif/indexed_list_insert_remove_unit_tb.sv @@
// Testbench top for the indexed list unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module indexed_list_insert_remove_unit_tb;
  import ilir_pkg::*;

  // The slowest correct run is roughly 200 items, about an eighth of them dumps
  // of up to 32 result items, each result stalled at random, plus one long
  // hold-off; the limit leaves ample room.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 200;
  localparam int HOLD_AT_RESULT = 60;
  localparam int HOLD_CYCLES    = 250;
  // After the last owed result the bench waits TAIL_CYCLES longer before the
  // verdict, so that stray result items are caught.
  localparam int TAIL_CYCLES    = 2 * ILIR_CAPACITY + 8;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_operation;
  logic [ILIR_POS_W-1:0]    in_position;
  logic signed [ILIR_VALUE_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic signed [ILIR_VALUE_W-1:0] out_entry_value;
  logic [ILIR_POS_W-1:0]    out_entry_position;
  logic [ILIR_COUNT_W-1:0]  out_entry_count;
  logic                     out_last;

  int   fail_count;
  int   pending_count;
  int   cycle_count   = 0;
  int   results_taken = 0;
  logic sender_calm   = 1'b0;

  // Stimulus loop variables.
  int   item_idx;
  int   phase;
  int   roll;
  op_t  rand_op;
  logic [ILIR_POS_W-1:0]          rand_pos;
  logic signed [ILIR_VALUE_W-1:0] rand_val;

  indexed_list_insert_remove_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_value    (out_entry_value),
    .out_entry_position (out_entry_position),
    .out_entry_count    (out_entry_count),
    .out_last           (out_last)
  );

  // The checker sits beside the block, watching both channels.
  ilir_list_checker i_list_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_value    (out_entry_value),
    .out_entry_position (out_entry_position),
    .out_entry_count    (out_entry_count),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** indexed_list_insert_remove_unit: FAILED **");
      $finish;
    end
  end

  // Offers one item. It is called at a falling edge and returns at the
  // falling edge after acceptance, so that valid is either kept high for the
  // next item or lowered for a gap, never both in the same step.
  task automatic send_item(op_t op, logic [ILIR_POS_W-1:0] pos,
                           logic signed [ILIR_VALUE_W-1:0] val);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side. It stalls at random before each result item, runs without
  // stalls for a stretch, and once holds off for a long while so that the
  // block backs up and refuses input items.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT_RESULT)
        stall = HOLD_CYCLES;
      else if (results_taken >= 150 && results_taken < 250)
        stall = 0;
      else
        stall = $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_APPEND;
    in_position  = '0;
    in_value     = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: empty-list cases first, then edits at both ends and in
    // the middle, out-of-range positions, and dumps of a partly filled list.
    send_item(OP_DUMP,   6'd0,  32'sd0);               // dump of an empty list
    send_item(OP_REMOVE, 6'd0,  32'sd0);               // remove from an empty list
    send_item(OP_INSERT, 6'd1,  32'sd5);               // insert past the end
    send_item(OP_INSERT, 6'd0,  32'h8000_0000);        // most negative word
    send_item(OP_APPEND, 6'd0,  32'h7FFF_FFFF);        // most positive word
    send_item(OP_APPEND, 6'd17, -32'sd1);
    send_item(OP_APPEND, 6'd0,  32'sd0);
    send_item(OP_INSERT, 6'd63, 32'sd9);               // highest position, out of range
    send_item(OP_INSERT, 6'd4,  32'h5A5A_5A5A);        // insert exactly at the end
    send_item(OP_INSERT, 6'd2,  32'h0F0F_F0F0);        // insert in the middle
    send_item(OP_REMOVE, 6'd63, 32'sd0);               // remove far past the end
    send_item(OP_REMOVE, 6'd6,  32'sd0);               // remove exactly at the count
    send_item(OP_DUMP,   6'd0,  32'sd0);
    send_item(OP_REMOVE, 6'd0,  32'sd0);               // remove the head
    send_item(OP_REMOVE, 6'd4,  32'sd0);               // remove the tail
    send_item(OP_APPEND, 6'd63, 32'h1234_5678);        // position is ignored here
    send_item(OP_DUMP,   6'd63, 32'hFFFF_0000);

    // Random items in phases: growth drives the list to full and holds it
    // there, then removals drain it, then an even mix. Most positions fall
    // near the valid range; a fifth span the whole field.
    for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
      sender_calm = (item_idx >= 60 && item_idx < 90);
      phase = (item_idx < 100) ? 0 : (item_idx < 150) ? 1 : 2;
      roll  = $urandom_range(0, 99);
      case (phase)
        0: rand_op = (roll < 40) ? OP_APPEND : (roll < 80) ? OP_INSERT :
                     (roll < 90) ? OP_REMOVE : OP_DUMP;
        1: rand_op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT :
                     (roll < 88) ? OP_REMOVE : OP_DUMP;
        default: rand_op = (roll < 28) ? OP_APPEND : (roll < 56) ? OP_INSERT :
                           (roll < 85) ? OP_REMOVE : OP_DUMP;
      endcase
      if ($urandom_range(0, 4) == 0)
        rand_pos = ILIR_POS_W'($urandom_range(0, 63));
      else
        rand_pos = ILIR_POS_W'($urandom_range(0, ILIR_CAPACITY + 2));
      roll = $urandom_range(0, 9);
      if (roll == 0)
        rand_val = 32'h8000_0000;
      else if (roll == 1)
        rand_val = 32'h7FFF_FFFF;
      else
        rand_val = $urandom;
      send_item(rand_op, rand_pos, rand_val);
    end
    sender_calm = 1'b0;
    in_valid <= 1'b0;

    // Wait for every owed result item, then a little longer to catch strays.
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("** indexed_list_insert_remove_unit: PASSED **");
    else
      $display("** indexed_list_insert_remove_unit: FAILED **");
    $finish;
  end

endmodule
